[hdl/dlr_pkg.sv]
// shared types and constants for the dense layer with relu
package dlr_pkg;

    localparam int NFIELD      = 4;
    localparam int DIM_DEFAULT = 4;
    localparam int DATA_W      = 16;
    localparam int OUT_W       = 15;
    localparam int PROD_W      = 2 * DATA_W;
    localparam int ACC_W       = PROD_W + 4;
    localparam int FRAC        = 8;
    localparam int OUT_MAX     = (1 << OUT_W) - 1;

    // action field codes
    typedef enum logic {
        ACT_LOAD    = 1'b0,
        ACT_COMPUTE = 1'b1
    } action_t;

    typedef logic signed [DATA_W-1:0] data_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [ACC_W-1:0]  acc_t;
    typedef logic [OUT_W-1:0]         out_t;

    typedef struct packed {
        out_t value;
        logic clip;
    } lane_result_t;

endpackage

[hdl/dlr_lane.sv]
// one output column: registered products, then sum, floor shift, relu and saturation
module dlr_lane (
    input  logic                  clk,
    input  logic                  load,
    input  dlr_pkg::data_t        act  [dlr_pkg::NFIELD],
    input  dlr_pkg::data_t        wcol [dlr_pkg::NFIELD],
    input  dlr_pkg::data_t        bias,
    output dlr_pkg::lane_result_t res
);
    import dlr_pkg::*;

    prod_t prod_reg [NFIELD];
    acc_t  acc;
    acc_t  scaled;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            for (int k = 0; k < NFIELD; k++)
            begin
                prod_reg[k] <= prod_t'(act[k]) * prod_t'(wcol[k]);
            end
        end
    end

    always_comb
    begin
        acc = acc_t'(bias) <<< FRAC;
        for (int k = 0; k < NFIELD; k++)
        begin
            acc = acc + acc_t'(prod_reg[k]);
        end
        // arithmetic shift rounds toward minus infinity
        scaled = acc >>> FRAC;
        if (scaled[ACC_W-1])
        begin
            res.value = '0;
            res.clip  = 1'b0;
        end
        else if (scaled > acc_t'(OUT_MAX))
        begin
            res.value = out_t'(OUT_MAX);
            res.clip  = 1'b1;
        end
        else
        begin
            res.value = scaled[OUT_W-1:0];
            res.clip  = 1'b0;
        end
    end

endmodule

[hdl/dlr_merge.sv]
// merges lane results into the output register and drives the result beat
module dlr_merge (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  load,
    input  dlr_pkg::lane_result_t res [dlr_pkg::NFIELD],
    input  logic                  out_ready,
    output logic                  out_valid,
    output logic                  free,
    output dlr_pkg::out_t         value [dlr_pkg::NFIELD],
    output logic                  clipped
);
    import dlr_pkg::*;

    logic valid_reg;
    logic valid_next;
    out_t value_reg [NFIELD];
    logic clip_reg;
    logic clip_any;

    assign free = !valid_reg || out_ready;

    always_comb
    begin
        clip_any = 1'b0;
        for (int j = 0; j < NFIELD; j++)
        begin
            clip_any = clip_any | res[j].clip;
        end
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            for (int j = 0; j < NFIELD; j++)
            begin
                value_reg[j] <= res[j].value;
            end
            clip_reg <= clip_any;
        end
    end

    assign out_valid = valid_reg;
    assign value     = value_reg;
    assign clipped   = clip_reg;

endmodule

[hdl/dense_layer_relu.sv]
// top level of the dense layer with relu: weight store, column lanes, output merge
//
// one 4x4 fully connected layer in signed q8.8. a beat with action 0 loads
// weight row row_select from in_0..in_3 and gives no result; a beat with
// action 1 carries four activations and gives one result beat with the four
// column outputs, each relu'd, floored from q20.16 to unsigned q7.8 and
// saturated at 32767, plus clipped when any column exceeded that limit. the
// layer takes one beat per cycle while out_ready keeps the output register
// free: the four column lanes multiply in parallel into a product register,
// and the sum, shift and clamp land in the output register after it.
// in_ready only drops when the output register holds an untaken result and
// the product stage is full. the weights sit in flip-flops cleared by reset,
// so no warm-up pass is needed. bias is written over the cfg port and must
// only change while the layer is idle. with DIM below 4 the unused columns
// report 0 and their weights and activations are ignored.
module dense_layer_relu #(
    parameter int DIM = dlr_pkg::DIM_DEFAULT
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  logic           action,
    input  logic [1:0]     row_select,
    input  dlr_pkg::data_t in_0,
    input  dlr_pkg::data_t in_1,
    input  dlr_pkg::data_t in_2,
    input  dlr_pkg::data_t in_3,
    output logic           out_valid,
    input  logic           out_ready,
    output dlr_pkg::out_t  out_0,
    output dlr_pkg::out_t  out_1,
    output dlr_pkg::out_t  out_2,
    output dlr_pkg::out_t  out_3,
    output logic           clipped,
    input  logic           cfg_valid,
    output logic           cfg_ready,
    input  dlr_pkg::data_t cfg_data
);
    import dlr_pkg::*;

    // active rows and columns: the fields carry at most four
    localparam int NL = (DIM < NFIELD) ? DIM : NFIELD;

    data_t        bias_reg;
    data_t        bias_next;
    data_t        w_reg  [NL][NL];
    data_t        w_next [NL][NL];
    logic         s1_valid_reg;
    logic         s1_valid_next;
    logic         accept;
    logic         free;
    data_t        act    [NFIELD];
    data_t        wcol   [NFIELD][NFIELD];
    lane_result_t res    [NFIELD];
    out_t         value  [NFIELD];

    assign cfg_ready = 1'b1;
    assign accept    = in_valid && in_ready;
    // the product stage moves on whenever the output register can take it
    assign in_ready  = !s1_valid_reg || free;

    assign act[0] = in_0;
    assign act[1] = in_1;
    assign act[2] = in_2;
    assign act[3] = in_3;

    // bias register
    always_comb
    begin
        bias_next = bias_reg;
        if (cfg_valid && cfg_ready)
        begin
            bias_next = cfg_data;
        end
    end

    // weight store: a row load writes the active columns of one row
    always_comb
    begin
        w_next = w_reg;
        if (accept && action == ACT_LOAD)
        begin
            for (int r = 0; r < NL; r++)
            begin
                if (row_select == 2'(r))
                begin
                    for (int c = 0; c < NL; c++)
                    begin
                        w_next[r][c] = act[c];
                    end
                end
            end
        end
    end

    // product stage occupancy: only compute beats enter the pipeline
    always_comb
    begin
        if (in_ready)
        begin
            s1_valid_next = accept && (action == ACT_COMPUTE);
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bias_reg     <= '0;
            s1_valid_reg <= 1'b0;
            for (int r = 0; r < NL; r++)
            begin
                for (int c = 0; c < NL; c++)
                begin
                    w_reg[r][c] <= '0;
                end
            end
        end
        else
        begin
            bias_reg     <= bias_next;
            s1_valid_reg <= s1_valid_next;
            w_reg        <= w_next;
        end
    end

    // column lanes; rows beyond the active set see zero weights
    for (genvar j = 0; j < NFIELD; j++)
    begin : g_col
        if (j < NL)
        begin : g_lane
            for (genvar k = 0; k < NFIELD; k++)
            begin : g_w
                if (k < NL)
                begin : g_on
                    assign wcol[j][k] = w_reg[k][j];
                end
                else
                begin : g_off
                    assign wcol[j][k] = '0;
                end
            end

            dlr_lane u_lane (
                .clk  (clk),
                .load (accept && action == ACT_COMPUTE),
                .act  (act),
                .wcol (wcol[j]),
                .bias (bias_reg),
                .res  (res[j])
            );
        end
        else
        begin : g_idle
            for (genvar k = 0; k < NFIELD; k++)
            begin : g_w
                assign wcol[j][k] = '0;
            end
            assign res[j] = '0;
        end
    end

    dlr_merge u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (s1_valid_reg && free),
        .res       (res),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .free      (free),
        .value     (value),
        .clipped   (clipped)
    );

    assign out_0 = value[0];
    assign out_1 = value[1];
    assign out_2 = value[2];
    assign out_3 = value[3];

    // an item enters the product stage only from an accepted compute beat
    a_s1_from_compute: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(s1_valid_reg) |-> $past(accept && action == ACT_COMPUTE))
        else $error("product stage filled without a compute beat");

    // an empty product stage never blocks the input
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid_reg |-> in_ready)
        else $error("input stalled with empty product stage");

    // clipped is only reported alongside a saturated column
    a_clip_has_max: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && clipped) |-> (out_0 == out_t'(OUT_MAX) || out_1 == out_t'(OUT_MAX)
            || out_2 == out_t'(OUT_MAX) || out_3 == out_t'(OUT_MAX)))
        else $error("clipped set with no saturated column");

endmodule
